// ===== src/prfl_pkg.sv =====
// Package for the paced FIFO rate limiter.
// Shared widths, reset values, register indexes and codes. No dependencies.
package prfl_pkg;

  localparam int QUEUE_DEPTH_DEF   = 1024;
  localparam int NS_PER_SECOND_DEF = 1000000000;

  localparam int RATE_W  = 32;
  localparam int LIMIT_W = 11;
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 16;
  localparam int TIME_W  = 64;

  localparam logic [RATE_W-1:0]  PACE_RATE_RST   = 32'hFFFF_FFFF;
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 11'd1000;

  // configuration register indexes
  localparam logic REG_PACE_RATE   = 1'b0;
  localparam logic REG_QUEUE_LIMIT = 1'b1;

  // request codes
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_ADD  = 5'b01000,
    S_DEQ  = 5'b10000
  } state_t;

endpackage

// ===== src/prfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module prfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/prfl_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on prfl_pkg (RATE_W).
module prfl_div #(
  parameter int DW = 46
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DW-1:0]             dividend,
  input  logic [prfl_pkg::RATE_W-1:0] divisor,
  output logic                      done,
  output logic [DW-1:0]             quotient
);
  import prfl_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     dvd;    // dividend bits shift out, quotient bits shift in
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dsr;
  logic [RATE_W:0]   rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    q_bit  = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      dvd <= {dvd[DW-2:0], q_bit};
      rem <= q_bit ? RATE_W'(rem_sh - {1'b0, dsr}) : rem_sh[RATE_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

// ===== src/paced_fifo_rate_limiter.sv =====
// Paced FIFO rate limiter. One request at a time; busy is high while it works.
// Enqueue: states S_MUL, S_DIV and S_ADD; in S_DIV the bit-serial divide of NS_PER_SECOND*length
//   by the pacing rate runs over DW = dividend bits (46 by default);
//   S_DIV is skipped if the rate is 0.
// Dequeue: one state, S_DEQ, and done is registered from it. Next start is taken the cycle done is shown.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Synchronous active-high reset empties the queue and restores register defaults.
module paced_fifo_rate_limiter #(
  parameter int QUEUE_DEPTH   = prfl_pkg::QUEUE_DEPTH_DEF,
  parameter int NS_PER_SECOND = prfl_pkg::NS_PER_SECOND_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [prfl_pkg::LEN_W-1:0]   packet_length,
  input  logic [prfl_pkg::TAG_W-1:0]   packet_tag,
  input  logic [prfl_pkg::TIME_W-1:0]  now_ns,
  input  logic                         wr_en,
  input  logic                         wr_index,
  input  logic [prfl_pkg::RATE_W-1:0]  wr_data,
  output logic                         done,
  output logic                         enqueue_dropped,
  output logic                         out_valid,
  output logic [prfl_pkg::LEN_W-1:0]   out_length,
  output logic [prfl_pkg::TAG_W-1:0]   out_tag,
  output logic                         wake_armed,
  output logic [prfl_pkg::TIME_W-1:0]  wake_time
);
  import prfl_pkg::*;

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int NSW   = $clog2(NS_PER_SECOND + 1);
  localparam int DW    = NSW + LEN_W;
  localparam int ENT_W = LEN_W + TAG_W + TIME_W;

  localparam logic [NSW-1:0] NS_C    = NSW'(NS_PER_SECOND);
  localparam logic [LW-1:0]  DEPTH_C = LW'(QUEUE_DEPTH);
  localparam logic [AW-1:0]  LAST_C  = AW'(QUEUE_DEPTH - 1);

  state_t state, state_next;

  logic [RATE_W-1:0]  pace_rate;
  logic [LIMIT_W-1:0] queue_limit;

  logic [LEN_W-1:0]   len_r;
  logic [TAG_W-1:0]   tag_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  base;
  logic [TIME_W-1:0]  last_due;
  logic [AW-1:0]      head, tail;
  logic [CW-1:0]      count;

  logic               div_start, div_done;
  logic [DW-1:0]      dividend, quotient;
  logic [TIME_W-1:0]  delay, due_new;
  logic [LW-1:0]      limit_ext, limit_eff;
  logic               has_space;

  logic               ram_we;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;
  logic [LEN_W-1:0]   head_len;
  logic [TAG_W-1:0]   head_tag;
  logic [TIME_W-1:0]  head_due;

  assign busy = (state != S_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pace_rate   <= PACE_RATE_RST;
      queue_limit <= QUEUE_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PACE_RATE:   pace_rate   <= wr_data;
        REG_QUEUE_LIMIT: queue_limit <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // multiply feeds the divider's input register
  assign dividend  = DW'(NS_C) * DW'(len_r);
  assign div_start = (state == S_MUL) && (pace_rate != '0);

  prfl_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (pace_rate),
    .done     (div_done),
    .quotient (quotient)
  );

  // rate was checked in S_MUL; the user must not change it while busy (not enforced here)
  assign delay   = (pace_rate == '0) ? '0 : TIME_W'(quotient);
  assign due_new = base + delay;

  assign limit_ext = LW'(queue_limit);
  assign limit_eff = (limit_ext < DEPTH_C) ? limit_ext : DEPTH_C;
  assign has_space = (LW'(count) < limit_eff);

  assign ram_we    = (state == S_ADD) && has_space;
  assign ram_wdata = {len_r, tag_r, due_new};
  assign {head_len, head_tag, head_due} = ram_rdata;

  prfl_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (action == ACT_DEQUEUE) ? S_DEQ : S_MUL;
        end
      end
      S_MUL:   state_next = (pace_rate == '0) ? S_ADD : S_DIV;
      S_DIV:   state_next = div_done ? S_ADD : S_DIV;
      S_ADD:   state_next = S_IDLE;
      S_DEQ:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      last_due <= '0;
    end else begin
      state <= state_next;
      if (state == S_ADD) begin
        last_due <= due_new;   // pacing clock moves even on a drop
        if (has_space) begin
          tail  <= (tail == LAST_C) ? '0 : tail + 1'b1;
          count <= count + 1'b1;
        end
      end
      if ((state == S_DEQ) && (count != '0) && (head_due <= now_r)) begin
        head  <= (head == LAST_C) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      len_r <= packet_length;
      tag_r <= packet_tag;
      now_r <= now_ns;
    end
    if (state == S_MUL) begin
      base <= (now_r > last_due) ? now_r : last_due;
    end
  end

  // result register, zero outside the done cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= 1'b0;
      enqueue_dropped <= 1'b0;
      out_valid       <= 1'b0;
      out_length      <= '0;
      out_tag         <= '0;
      wake_armed      <= 1'b0;
      wake_time       <= '0;
    end else begin
      done            <= (state == S_ADD) || (state == S_DEQ);
      enqueue_dropped <= (state == S_ADD) && !has_space;
      out_valid       <= 1'b0;
      out_length      <= '0;
      out_tag         <= '0;
      wake_armed      <= 1'b0;
      wake_time       <= '0;
      if ((state == S_DEQ) && (count != '0)) begin
        if (head_due <= now_r) begin
          out_valid  <= 1'b1;
          out_length <= head_len;
          out_tag    <= head_tag;
        end else begin
          wake_armed <= 1'b1;
          wake_time  <= head_due;
        end
      end
    end
  end

endmodule

// ===== src/prfl_checker.sv =====
// Port-level checks for the paced FIFO rate limiter, bound to the top level.
// Depends on prfl_pkg and paced_fifo_rate_limiter.
module prfl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         enqueue_dropped,
  input logic                         out_valid,
  input logic                         wake_armed,
  input logic [prfl_pkg::TIME_W-1:0]  wake_time
);
  import prfl_pkg::*;

  // an accepted request keeps the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result strobe while busy or held two cycles");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({enqueue_dropped, out_valid, wake_armed}) <= 1))
    else $error("more than one outcome in one result");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!enqueue_dropped && !out_valid && !wake_armed))
    else $error("result flags set without strobe");

  a_wake_zero: assert property (@(posedge clk) disable iff (rst)
    !wake_armed |-> (wake_time == '0))
    else $error("wake time nonzero while not armed");

endmodule

bind paced_fifo_rate_limiter prfl_checker u_prfl_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .enqueue_dropped (enqueue_dropped),
  .out_valid       (out_valid),
  .wake_armed      (wake_armed),
  .wake_time       (wake_time)
);

// ===== tb/tb.sv =====
// Testbench for paced_fifo_rate_limiter: directed and random enqueue/dequeue requests,
// register changes between phases, every result checked against an in-bench pacing FIFO.
// Depends on prfl_pkg and the RTL under src/.
module tb;
  import prfl_pkg::*;

  localparam int          DEPTH      = QUEUE_DEPTH_DEF;
  localparam logic [63:0] NS_PER_SEC = NS_PER_SECOND_DEF;
  localparam int          STALL_MAX  = 2000;

  typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic               act;
    logic [LEN_W-1:0]   len;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  now;
    logic               idx;
    logic [RATE_W-1:0]  data;
    int                 gap;
  } step_t;

  typedef struct packed {
    logic               dropped;
    logic               valid;
    logic [LEN_W-1:0]   length;
    logic [TAG_W-1:0]   tag;
    logic               armed;
    logic [TIME_W-1:0]  wake;
  } pace_out_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic                action        = ACT_ENQUEUE;
  logic [LEN_W-1:0]    packet_length = '0;
  logic [TAG_W-1:0]    packet_tag    = '0;
  logic [TIME_W-1:0]   now_ns        = '0;
  logic                wr_en         = 1'b0;
  logic                wr_index      = REG_PACE_RATE;
  logic [RATE_W-1:0]   wr_data       = '0;
  logic                busy;
  logic                done;
  logic                enqueue_dropped;
  logic                out_valid;
  logic [LEN_W-1:0]    out_length;
  logic [TAG_W-1:0]    out_tag;
  logic                wake_armed;
  logic [TIME_W-1:0]   wake_time;

  // pacing FIFO as predicted by the bench
  logic [RATE_W-1:0]   pace_rate     = PACE_RATE_RST;
  logic [LIMIT_W-1:0]  pace_limit    = QUEUE_LIMIT_RST;
  logic [LEN_W-1:0]    ring_len [DEPTH];
  logic [TAG_W-1:0]    ring_tag [DEPTH];
  logic [TIME_W-1:0]   ring_due [DEPTH];
  int                  ring_head     = 0;
  int                  ring_tail     = 0;
  int                  ring_count    = 0;
  logic [TIME_W-1:0]   pace_last_due = '0;

  step_t               steps_q[$];
  pace_out_t           pace_out_q[$];
  step_t               cur_step;
  logic [TIME_W-1:0]   gen_now;

  int n_issued = 0, n_done = 0, n_err = 0, gap_left = 0, idle_cycles = 0, n_planned = 0;
  int n_enq = 0, n_drop = 0, n_freed = 0, n_wake = 0, n_cancel = 0, n_writes = 0;

  paced_fifo_rate_limiter u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .packet_length   (packet_length),
    .packet_tag      (packet_tag),
    .now_ns          (now_ns),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .done            (done),
    .enqueue_dropped (enqueue_dropped),
    .out_valid       (out_valid),
    .out_length      (out_length),
    .out_tag         (out_tag),
    .wake_armed      (wake_armed),
    .wake_time       (wake_time)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic pace_step(input step_t r);
    pace_out_t        res;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] due;
    int               lim;
    res = '0;
    if (r.act == ACT_ENQUEUE) begin
      n_enq++;
      delay = (pace_rate != 0) ? (NS_PER_SEC * {48'd0, r.len}) / {32'd0, pace_rate} : '0;
      base = (r.now > pace_last_due) ? r.now : pace_last_due;
      // pacing clock moves on even when the packet is dropped
      pace_last_due = base + delay;
      lim = (pace_limit > DEPTH) ? DEPTH : pace_limit;
      if (ring_count < lim) begin
        ring_len[ring_tail] = r.len;
        ring_tag[ring_tail] = r.tag;
        ring_due[ring_tail] = pace_last_due;
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_count++;
      end else begin
        res.dropped = 1'b1;
        n_drop++;
      end
    end else if (ring_count == 0) begin
      n_cancel++;
    end else begin
      due = ring_due[ring_head];
      if (due <= r.now) begin
        res.valid  = 1'b1;
        res.length = ring_len[ring_head];
        res.tag    = ring_tag[ring_head];
        ring_head = (ring_head + 1) % DEPTH;
        ring_count--;
        n_freed++;
      end else begin
        res.armed = 1'b1;
        res.wake  = due;
        n_wake++;
      end
    end
    pace_out_q.push_back(res);
  endtask

  task automatic set_reg(input logic idx, input logic [RATE_W-1:0] data);
    if (idx == REG_PACE_RATE) pace_rate = data;
    else pace_limit = data[LIMIT_W-1:0];
    n_writes++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (((n_planned / 48) % 4) == 3) return 0;  // back-to-back stretch
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_req(input logic act, input logic [LEN_W-1:0] len,
                         input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
    step_t s;
    s.kind = STEP_REQ;
    s.act  = act;
    s.len  = len;
    s.tag  = tag;
    s.now  = now;
    s.idx  = REG_PACE_RATE;
    s.data = '0;
    s.gap  = pick_gap();
    steps_q.push_back(s);
    n_planned++;
  endtask

  task automatic add_ctl(input step_kind_t kind, input logic idx, input logic [RATE_W-1:0] data);
    step_t s;
    s.kind = kind;
    s.act  = ACT_ENQUEUE;
    s.len  = '0;
    s.tag  = '0;
    s.now  = '0;
    s.idx  = idx;
    s.data = data;
    s.gap  = 0;
    steps_q.push_back(s);
  endtask

  task automatic run_mix(input int n, input int pct_enq, input int max_len, input int max_step);
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
    logic             act;
    for (int i = 0; i < n; i++) begin
      gen_now += $urandom_range(0, max_step);
      len = ($urandom_range(0, 19) == 0) ? LEN_W'($urandom)
                                         : LEN_W'($urandom_range(0, max_len));
      tag = TAG_W'($urandom);
      act = ($urandom_range(0, 99) < pct_enq) ? ACT_ENQUEUE : ACT_DEQUEUE;
      add_req(act, len, tag, gen_now);
    end
  endtask

  // request driver: one outstanding start, register writes only when drained
  always @(posedge clk) begin : drive_proc
    step_t s;
    logic  go;
    logic  wr_go;
    logic  drained;
    if (rst) begin
      start <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      go      = start;
      wr_go   = 1'b0;
      drained = (n_issued == n_done) && !start && !busy;
      if (start && !busy) begin
        pace_step(cur_step);
        n_issued <= n_issued + 1;
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (steps_q.size() != 0) begin
          s = steps_q[0];
          case (s.kind)
            STEP_REQ: begin
              s = steps_q.pop_front();
              cur_step      = s;
              action        <= s.act;
              packet_length <= s.len;
              packet_tag    <= s.tag;
              now_ns        <= s.now;
              gap_left      = s.gap;
              go = 1'b1;
            end
            STEP_CFG: if (drained) begin
              s = steps_q.pop_front();
              wr_index <= s.idx;
              wr_data  <= s.data;
              set_reg(s.idx, s.data);
              wr_go = 1'b1;
            end
            default: if (drained) begin
              s = steps_q.pop_front();
            end
          endcase
        end
      end
      start <= go;
      wr_en <= wr_go;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : check_proc
    pace_out_t want;
    if (!rst && done === 1'b1) begin
      n_done <= n_done + 1;
      if (pace_out_q.size() == 0) begin
        $error("result shown with no request pending");
        n_err++;
      end else begin
        want = pace_out_q.pop_front();
        check_field("enqueue_dropped", want.dropped, enqueue_dropped);
        check_field("out_valid", want.valid, out_valid);
        check_field("out_length", want.length, out_length);
        check_field("out_tag", want.tag, out_tag);
        check_field("wake_armed", want.armed, wake_armed);
        check_field("wake_time", want.wake, wake_time);
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (idle_cycles >= STALL_MAX) begin
      $display("No request or result for %0d cycles", STALL_MAX);
      $display("Simulation FAILED");
      $finish;
    end else if (rst || (start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // directed: register defaults first, then extreme rates and limits
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd0);              // empty queue cancels
    add_req(ACT_ENQUEUE, 16'd0, 16'd0, 64'd0);
    add_req(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF, 64'd5);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd0);              // due exactly now
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd10);             // head not due yet
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd15263);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd15263);
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'd0);                // no pacing delay
    add_req(ACT_ENQUEUE, 16'd1500, 16'h5A5A, 64'd100);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd15262);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd15263);
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'd1);
    add_req(ACT_ENQUEUE, 16'hFFFF, 16'hA5A5, '1);           // due time wraps
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, '1);
    add_req(ACT_ENQUEUE, 16'd1, 16'd1, 64'd0);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, 64'd0);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, '1);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd0);              // drops all, clock still moves
    add_req(ACT_ENQUEUE, 16'd2, 16'd2, 64'd0);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, '1);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd1);
    add_req(ACT_ENQUEUE, 16'd0, 16'h1234, 64'd0);
    add_req(ACT_ENQUEUE, 16'd0, 16'h4321, 64'd0);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, '1);
    add_req(ACT_DEQUEUE, 16'd0, 16'd0, '1);

    // moderate pacing with a small queue
    gen_now = 64'h0004_0000_0000_0000;
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'd1_000_000);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd16);
    run_mix(80, 50, 1500, 800_000);
    add_ctl(STEP_DRAIN, REG_PACE_RATE, '0);
    run_mix(80, 50, 1500, 800_000);

    // limit above storage: build a deep queue, then empty it
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'd0);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd2047);
    gen_now += 64'd1_000_000_000_000;
    for (int i = 0; i < 120; i++) begin
      gen_now += $urandom_range(0, 1000);
      add_req(ACT_ENQUEUE, LEN_W'($urandom), TAG_W'($urandom), gen_now);
    end
    for (int i = 0; i < 120; i++) begin
      gen_now += $urandom_range(0, 1000);
      add_req(ACT_DEQUEUE, LEN_W'($urandom), TAG_W'($urandom), gen_now);
    end

    // fastest nonzero pacing, full-size queue
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'hFFFF_FFFF);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd1024);
    run_mix(70, 50, 65535, 16000);
    add_ctl(STEP_DRAIN, REG_PACE_RATE, '0);
    run_mix(70, 50, 65535, 16000);

    // slowest pacing, tiny queue: many drops and wake timers
    add_ctl(STEP_CFG, REG_PACE_RATE, 32'd1);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, 32'd3);
    run_mix(80, 55, 3, 2_000_000_000);

    // noise: random registers (upper data bits too) and fully random fields
    add_ctl(STEP_CFG, REG_PACE_RATE, $urandom);
    add_ctl(STEP_CFG, REG_QUEUE_LIMIT, $urandom);
    for (int i = 0; i < 60; i++) begin
      add_req($urandom_range(0, 1) ? ACT_DEQUEUE : ACT_ENQUEUE, LEN_W'($urandom),
              TAG_W'($urandom), ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom});
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (steps_q.size() != 0 || start || n_issued != n_done) @(posedge clk);
    repeat (80) @(posedge clk);

    if (pace_out_q.size() != 0) begin
      $error("%0d results never arrived", pace_out_q.size());
      n_err++;
    end
    $display("Ran %0d requests over %0d register writes: %0d enqueues (%0d dropped),",
             n_issued, n_writes, n_enq, n_drop);
    $display("  %0d packets freed, %0d wake timers armed, %0d empty-queue cancels",
             n_freed, n_wake, n_cancel);
    if (n_err == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
